// ===== design/cpp_pkg.sv =====
package cpp_pkg;

  // point and flag widths
  localparam int COORD_BITS = 24;
  localparam int FLAG_BITS  = 16;
  localparam int DIST_BITS  = 16;
  localparam int DIST_RESET = 256;

  // datapath widths
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int MUL_BITS   = (COORD_BITS + 1 > 2 * DIST_BITS) ? COORD_BITS + 1 : 2 * DIST_BITS;
  localparam int PROD_BITS  = 2 * MUL_BITS;
  localparam int CROSS_BITS = PROD_BITS + 2;
  localparam int ACC_BITS   = 4 * MUL_BITS + 4;
  localparam int T2_BITS    = 2 * DIST_BITS;

  // microcode store
  localparam int PC_BITS = 5;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
    logic [FLAG_BITS-1:0]         area_flags;
    logic                         final_point;
  } point_in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic signed [COORD_BITS-1:0] out_z;
    logic [FLAG_BITS-1:0]         out_flags;
    logic                         path_end;
  } point_out_t;

  // step hold condition
  typedef enum logic [1:0] {
    WAIT_NONE,
    WAIT_IN,
    WAIT_OUT,
    WAIT_OUT_LAST
  } wait_t;

  // branch condition
  typedef enum logic [2:0] {
    BR_NEVER,
    BR_ALWAYS,
    BR_NOT_ACTIVE,
    BR_PTS_ONE,
    BR_NO_TEST,
    BR_REMOVABLE
  } br_t;

  // multiplier operand source
  typedef enum logic [3:0] {
    OPD_ZERO,
    OPD_AB0,
    OPD_AB1,
    OPD_AB2,
    OPD_AC0,
    OPD_AC1,
    OPD_AC2,
    OPD_XLO,
    OPD_XHI,
    OPD_LLO,
    OPD_LHI,
    OPD_DIST,
    OPD_T2
  } opnd_t;

  // what happens to the previous step's product
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_CR_SET,
    ACT_CR_SUB,
    ACT_T2_SET,
    ACT_LEN_SET,
    ACT_LEN_ADD,
    ACT_ACC_ADD,
    ACT_ACC_SUB
  } act_t;

  // product alignment into the accumulator
  typedef enum logic [1:0] {
    SH_0,
    SH_LIMB,
    SH_LIMB2,
    SH_TWO
  } sh_t;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_PEND,
    EMIT_CUR,
    EMIT_CUR_LAST
  } emit_t;

  typedef enum logic [1:0] {
    UPD_NONE,
    UPD_ANCHOR,
    UPD_TAIL,
    UPD_FIRST
  } upd_t;

  // one control word
  typedef struct packed {
    logic               take_in;
    wait_t              wt;
    br_t                br;
    logic [PC_BITS-1:0] target;
    opnd_t              opa;
    opnd_t              opb;
    act_t               act;
    sh_t                sh;
    logic               xm_load;
    emit_t              emit;
    upd_t               upd;
  } ctrl_t;

  // datapath flags seen by the sequencer
  typedef struct packed {
    logic out_free;
    logic cur_last;
    logic active;
    logic pts_one;
    logic no_test;
    logic removable;
  } status_t;

endpackage

// ===== design/cpp_seq.sv =====
module cpp_seq (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  cpp_pkg::status_t st,
  output logic             in_ready,
  output cpp_pkg::ctrl_t   cw
);

  localparam logic [cpp_pkg::PC_BITS-1:0] PC_WAIT  = cpp_pkg::PC_BITS'(0);
  localparam logic [cpp_pkg::PC_BITS-1:0] PC_KEEP  = cpp_pkg::PC_BITS'(28);
  localparam logic [cpp_pkg::PC_BITS-1:0] PC_TAIL  = cpp_pkg::PC_BITS'(29);
  localparam logic [cpp_pkg::PC_BITS-1:0] PC_FIRST = cpp_pkg::PC_BITS'(30);

  logic [cpp_pkg::PC_BITS-1:0] pc;
  logic [cpp_pkg::PC_BITS-1:0] pc_next;
  cpp_pkg::ctrl_t              word;
  logic                        go;
  logic                        taken;

  // control store
  function automatic cpp_pkg::ctrl_t uc_rom(input logic [cpp_pkg::PC_BITS-1:0] a);
    cpp_pkg::ctrl_t w;
    w = '0;
    w.wt     = cpp_pkg::WAIT_NONE;
    w.br     = cpp_pkg::BR_NEVER;
    w.target = PC_WAIT;
    w.opa    = cpp_pkg::OPD_ZERO;
    w.opb    = cpp_pkg::OPD_ZERO;
    w.act    = cpp_pkg::ACT_NONE;
    w.sh     = cpp_pkg::SH_0;
    w.emit   = cpp_pkg::EMIT_NONE;
    w.upd    = cpp_pkg::UPD_NONE;
    unique case (a)
      // wait for a point
      5'd0: begin
        w.take_in = 1'b1;
        w.wt      = cpp_pkg::WAIT_IN;
      end
      // dispatch on path position
      5'd1: begin
        w.br = cpp_pkg::BR_NOT_ACTIVE;
        w.target = PC_FIRST;
      end
      5'd2: begin
        w.br = cpp_pkg::BR_PTS_ONE;
        w.target = PC_TAIL;
      end
      5'd3: begin
        w.br = cpp_pkg::BR_NO_TEST;
        w.target = PC_KEEP;
      end
      // x component of cross product
      5'd4: begin
        w.opa = cpp_pkg::OPD_AB1; w.opb = cpp_pkg::OPD_AC2;
      end
      5'd5: begin
        w.opa = cpp_pkg::OPD_AB2; w.opb = cpp_pkg::OPD_AC1;
        w.act = cpp_pkg::ACT_CR_SET;
      end
      5'd6: begin
        w.opa = cpp_pkg::OPD_DIST; w.opb = cpp_pkg::OPD_DIST;
        w.act = cpp_pkg::ACT_CR_SUB;
      end
      5'd7: begin
        w.opa = cpp_pkg::OPD_AC0; w.opb = cpp_pkg::OPD_AC0;
        w.act = cpp_pkg::ACT_T2_SET; w.xm_load = 1'b1;
      end
      5'd8: begin
        w.opa = cpp_pkg::OPD_XLO; w.opb = cpp_pkg::OPD_XLO;
        w.act = cpp_pkg::ACT_LEN_SET;
      end
      5'd9: begin
        w.opa = cpp_pkg::OPD_XLO; w.opb = cpp_pkg::OPD_XHI;
        w.act = cpp_pkg::ACT_ACC_ADD; w.sh = cpp_pkg::SH_0;
      end
      5'd10: begin
        w.opa = cpp_pkg::OPD_XHI; w.opb = cpp_pkg::OPD_XHI;
        w.act = cpp_pkg::ACT_ACC_ADD; w.sh = cpp_pkg::SH_LIMB2;
      end
      // y component
      5'd11: begin
        w.opa = cpp_pkg::OPD_AB2; w.opb = cpp_pkg::OPD_AC0;
        w.act = cpp_pkg::ACT_ACC_ADD; w.sh = cpp_pkg::SH_TWO;
      end
      5'd12: begin
        w.opa = cpp_pkg::OPD_AB0; w.opb = cpp_pkg::OPD_AC2;
        w.act = cpp_pkg::ACT_CR_SET;
      end
      5'd13: begin
        w.opa = cpp_pkg::OPD_AC1; w.opb = cpp_pkg::OPD_AC1;
        w.act = cpp_pkg::ACT_CR_SUB;
      end
      5'd14: begin
        w.opa = cpp_pkg::OPD_AB0; w.opb = cpp_pkg::OPD_AC1;
        w.act = cpp_pkg::ACT_LEN_ADD; w.xm_load = 1'b1;
      end
      5'd15: begin
        w.opa = cpp_pkg::OPD_XLO; w.opb = cpp_pkg::OPD_XLO;
        w.act = cpp_pkg::ACT_CR_SET;
      end
      5'd16: begin
        w.opa = cpp_pkg::OPD_XLO; w.opb = cpp_pkg::OPD_XHI;
        w.act = cpp_pkg::ACT_ACC_ADD; w.sh = cpp_pkg::SH_0;
      end
      5'd17: begin
        w.opa = cpp_pkg::OPD_XHI; w.opb = cpp_pkg::OPD_XHI;
        w.act = cpp_pkg::ACT_ACC_ADD; w.sh = cpp_pkg::SH_LIMB2;
      end
      // z component
      5'd18: begin
        w.opa = cpp_pkg::OPD_AB1; w.opb = cpp_pkg::OPD_AC0;
        w.act = cpp_pkg::ACT_ACC_ADD; w.sh = cpp_pkg::SH_TWO;
      end
      5'd19: begin
        w.opa = cpp_pkg::OPD_AC2; w.opb = cpp_pkg::OPD_AC2;
        w.act = cpp_pkg::ACT_CR_SUB;
      end
      5'd20: begin
        w.act = cpp_pkg::ACT_LEN_ADD; w.xm_load = 1'b1;
      end
      5'd21: begin
        w.opa = cpp_pkg::OPD_XLO; w.opb = cpp_pkg::OPD_XLO;
      end
      5'd22: begin
        w.opa = cpp_pkg::OPD_XLO; w.opb = cpp_pkg::OPD_XHI;
        w.act = cpp_pkg::ACT_ACC_ADD; w.sh = cpp_pkg::SH_0;
      end
      5'd23: begin
        w.opa = cpp_pkg::OPD_XHI; w.opb = cpp_pkg::OPD_XHI;
        w.act = cpp_pkg::ACT_ACC_ADD; w.sh = cpp_pkg::SH_LIMB2;
      end
      // limit squared times length squared
      5'd24: begin
        w.opa = cpp_pkg::OPD_T2; w.opb = cpp_pkg::OPD_LLO;
        w.act = cpp_pkg::ACT_ACC_ADD; w.sh = cpp_pkg::SH_TWO;
      end
      5'd25: begin
        w.opa = cpp_pkg::OPD_T2; w.opb = cpp_pkg::OPD_LHI;
        w.act = cpp_pkg::ACT_ACC_SUB; w.sh = cpp_pkg::SH_0;
      end
      5'd26: begin
        w.act = cpp_pkg::ACT_ACC_SUB; w.sh = cpp_pkg::SH_LIMB;
      end
      5'd27: begin
        w.br = cpp_pkg::BR_REMOVABLE;
        w.target = PC_TAIL;
      end
      // pending point is kept
      5'd28: begin
        w.wt   = cpp_pkg::WAIT_OUT;
        w.emit = cpp_pkg::EMIT_PEND;
        w.upd  = cpp_pkg::UPD_ANCHOR;
      end
      // new point becomes pending or closes the path
      5'd29: begin
        w.wt   = cpp_pkg::WAIT_OUT_LAST;
        w.emit = cpp_pkg::EMIT_CUR_LAST;
        w.upd  = cpp_pkg::UPD_TAIL;
        w.br   = cpp_pkg::BR_ALWAYS;
        w.target = PC_WAIT;
      end
      // first point of a path
      5'd30: begin
        w.wt   = cpp_pkg::WAIT_OUT;
        w.emit = cpp_pkg::EMIT_CUR;
        w.upd  = cpp_pkg::UPD_FIRST;
        w.br   = cpp_pkg::BR_ALWAYS;
        w.target = PC_WAIT;
      end
      default: begin
        w.br = cpp_pkg::BR_ALWAYS;
        w.target = PC_WAIT;
      end
    endcase
    return w;
  endfunction

  assign word     = uc_rom(pc);
  assign in_ready = word.take_in;

  // hold and branch conditions
  always_comb begin
    unique case (word.wt)
      cpp_pkg::WAIT_NONE:     go = 1'b1;
      cpp_pkg::WAIT_IN:       go = in_valid;
      cpp_pkg::WAIT_OUT:      go = st.out_free;
      cpp_pkg::WAIT_OUT_LAST: go = !st.cur_last || st.out_free;
      default:                go = 1'b1;
    endcase
    unique case (word.br)
      cpp_pkg::BR_NEVER:      taken = 1'b0;
      cpp_pkg::BR_ALWAYS:     taken = 1'b1;
      cpp_pkg::BR_NOT_ACTIVE: taken = !st.active;
      cpp_pkg::BR_PTS_ONE:    taken = st.pts_one;
      cpp_pkg::BR_NO_TEST:    taken = st.no_test;
      cpp_pkg::BR_REMOVABLE:  taken = st.removable;
      default:                taken = 1'b0;
    endcase
  end

  // step counter
  always_comb begin
    if (!go) begin
      pc_next = pc;
    end else if (taken) begin
      pc_next = word.target;
    end else begin
      pc_next = pc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

  // held steps drive no actions
  always_comb begin
    cw = word;
    if (!go) begin
      cw.take_in = 1'b0;
      cw.act     = cpp_pkg::ACT_NONE;
      cw.xm_load = 1'b0;
      cw.emit    = cpp_pkg::EMIT_NONE;
      cw.upd     = cpp_pkg::UPD_NONE;
    end
  end

endmodule

// ===== design/cpp_dp.sv =====
module cpp_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  cpp_pkg::ctrl_t                cw,
  input  cpp_pkg::point_in_t            in_data,
  input  logic                          out_ready,
  output logic                          out_valid,
  output cpp_pkg::point_out_t           out_data,
  input  logic                          cfg_valid,
  input  logic [cpp_pkg::DIST_BITS-1:0] cfg_data,
  output cpp_pkg::status_t              st
);

  localparam int CB = cpp_pkg::COORD_BITS;
  localparam int DB = cpp_pkg::DIFF_BITS;
  localparam int MB = cpp_pkg::MUL_BITS;
  localparam int PB = cpp_pkg::PROD_BITS;
  localparam int XB = cpp_pkg::CROSS_BITS;
  localparam int AB = cpp_pkg::ACC_BITS;

  typedef enum logic [1:0] {
    PTS_NEW,
    PTS_ANCHOR,
    PTS_PENDING
  } pts_t;

  pts_t                          pts;
  logic signed [CB-1:0]          a_pos [3];
  logic signed [CB-1:0]          p_pos [3];
  logic signed [CB-1:0]          c_pos [3];
  logic signed [CB-1:0]          in_pos [3];
  logic [cpp_pkg::FLAG_BITS-1:0] a_area;
  logic [cpp_pkg::FLAG_BITS-1:0] p_area;
  logic [cpp_pkg::FLAG_BITS-1:0] c_area;
  logic                          c_last;
  logic [cpp_pkg::DIST_BITS-1:0] dist_limit;

  logic signed [DB-1:0]          ab [3];
  logic signed [DB-1:0]          ac [3];
  logic [DB-1:0]                 ab_mag [3];
  logic [DB-1:0]                 ac_mag [3];

  cpp_pkg::opnd_t                sel [2];
  logic [MB-1:0]                 op_val [2];
  logic                          op_neg [2];
  logic [PB-1:0]                 prod;
  logic                          prod_neg;
  logic signed [PB:0]            sprod;
  logic signed [XB-1:0]          cr;
  logic [XB-1:0]                 cr_abs;
  logic [PB-1:0]                 xm;
  logic [PB-1:0]                 len;
  logic [cpp_pkg::T2_BITS-1:0]   t2;
  logic [AB-1:0]                 acc;
  logic [AB-1:0]                 pext;
  logic [AB-1:0]                 shv;

  logic                          load;
  logic                          emit_fire;
  logic                          out_free;

  assign in_pos[0] = in_data.pos_x;
  assign in_pos[1] = in_data.pos_y;
  assign in_pos[2] = in_data.pos_z;
  assign load      = cw.take_in;

  // difference magnitudes
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ab_mag[k] = ab[k][DB-1] ? DB'(-ab[k]) : DB'(ab[k]);
      ac_mag[k] = ac[k][DB-1] ? DB'(-ac[k]) : DB'(ac[k]);
    end
  end

  // multiplier operand selection, sign kept aside
  assign sel[0] = cw.opa;
  assign sel[1] = cw.opb;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      op_val[i] = '0;
      op_neg[i] = 1'b0;
      case (sel[i])
        cpp_pkg::OPD_AB0: begin op_val[i] = MB'(ab_mag[0]); op_neg[i] = ab[0][DB-1]; end
        cpp_pkg::OPD_AB1: begin op_val[i] = MB'(ab_mag[1]); op_neg[i] = ab[1][DB-1]; end
        cpp_pkg::OPD_AB2: begin op_val[i] = MB'(ab_mag[2]); op_neg[i] = ab[2][DB-1]; end
        cpp_pkg::OPD_AC0: begin op_val[i] = MB'(ac_mag[0]); op_neg[i] = ac[0][DB-1]; end
        cpp_pkg::OPD_AC1: begin op_val[i] = MB'(ac_mag[1]); op_neg[i] = ac[1][DB-1]; end
        cpp_pkg::OPD_AC2: begin op_val[i] = MB'(ac_mag[2]); op_neg[i] = ac[2][DB-1]; end
        cpp_pkg::OPD_XLO:  op_val[i] = xm[MB-1:0];
        cpp_pkg::OPD_XHI:  op_val[i] = xm[PB-1:MB];
        cpp_pkg::OPD_LLO:  op_val[i] = len[MB-1:0];
        cpp_pkg::OPD_LHI:  op_val[i] = len[PB-1:MB];
        cpp_pkg::OPD_DIST: op_val[i] = MB'(dist_limit);
        cpp_pkg::OPD_T2:   op_val[i] = MB'(t2);
        default: begin
          op_val[i] = '0;
          op_neg[i] = 1'b0;
        end
      endcase
    end
  end

  // shared multiplier, registered product
  always_ff @(posedge clk) begin
    prod     <= op_val[0] * op_val[1];
    prod_neg <= op_neg[0] ^ op_neg[1];
  end

  assign sprod  = prod_neg ? -$signed({1'b0, prod}) : $signed({1'b0, prod});
  assign cr_abs = cr[XB-1] ? XB'(-cr) : XB'(cr);

  // product alignment for the accumulator
  assign pext = AB'(prod);

  always_comb begin
    case (cw.sh)
      cpp_pkg::SH_0:     shv = pext;
      cpp_pkg::SH_LIMB:  shv = pext << MB;
      cpp_pkg::SH_LIMB2: shv = pext << (MB + 1);
      cpp_pkg::SH_TWO:   shv = pext << (2 * MB);
      default:           shv = pext;
    endcase
  end

  // arithmetic registers
  always_ff @(posedge clk) begin
    if (load) begin
      acc <= '0;
      for (int k = 0; k < 3; k++) begin
        ab[k] <= DB'(p_pos[k]) - DB'(a_pos[k]);
        ac[k] <= DB'(in_pos[k]) - DB'(a_pos[k]);
      end
    end else begin
      case (cw.act)
        cpp_pkg::ACT_ACC_ADD: acc <= acc + shv;
        cpp_pkg::ACT_ACC_SUB: acc <= acc - shv;
        default: ;
      endcase
    end
    case (cw.act)
      cpp_pkg::ACT_CR_SET:  cr  <= XB'(sprod);
      cpp_pkg::ACT_CR_SUB:  cr  <= cr - XB'(sprod);
      cpp_pkg::ACT_T2_SET:  t2  <= prod[cpp_pkg::T2_BITS-1:0];
      cpp_pkg::ACT_LEN_SET: len <= prod;
      cpp_pkg::ACT_LEN_ADD: len <= len + prod;
      default: ;
    endcase
    if (cw.xm_load) begin
      xm <= cr_abs[PB-1:0];
    end
  end

  // path state
  always_ff @(posedge clk) begin
    if (rst) begin
      pts <= PTS_NEW;
    end else begin
      case (cw.upd)
        cpp_pkg::UPD_TAIL:  pts <= c_last ? PTS_NEW : PTS_PENDING;
        cpp_pkg::UPD_FIRST: pts <= c_last ? PTS_NEW : PTS_ANCHOR;
        default: ;
      endcase
    end
  end

  // point registers
  always_ff @(posedge clk) begin
    if (load) begin
      c_pos  <= in_pos;
      c_area <= in_data.area_flags;
      c_last <= in_data.final_point;
    end
    case (cw.upd)
      cpp_pkg::UPD_ANCHOR: begin
        a_pos  <= p_pos;
        a_area <= p_area;
      end
      cpp_pkg::UPD_TAIL: begin
        if (!c_last) begin
          p_pos  <= c_pos;
          p_area <= c_area;
        end
      end
      cpp_pkg::UPD_FIRST: begin
        a_pos  <= c_pos;
        a_area <= c_area;
      end
      default: ;
    endcase
  end

  // distance limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      dist_limit <= cpp_pkg::DIST_BITS'(cpp_pkg::DIST_RESET);
    end else if (cfg_valid) begin
      dist_limit <= cfg_data;
    end
  end

  // output register
  assign out_free  = !out_valid || out_ready;
  assign emit_fire = (cw.emit == cpp_pkg::EMIT_PEND) || (cw.emit == cpp_pkg::EMIT_CUR) ||
                     ((cw.emit == cpp_pkg::EMIT_CUR_LAST) && c_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      if (cw.emit == cpp_pkg::EMIT_PEND) begin
        out_data.out_x     <= p_pos[0];
        out_data.out_y     <= p_pos[1];
        out_data.out_z     <= p_pos[2];
        out_data.out_flags <= p_area;
        out_data.path_end  <= 1'b0;
      end else begin
        out_data.out_x     <= c_pos[0];
        out_data.out_y     <= c_pos[1];
        out_data.out_z     <= c_pos[2];
        out_data.out_flags <= c_area;
        out_data.path_end  <= c_last;
      end
    end
  end

  // status to the sequencer
  assign st.out_free  = out_free;
  assign st.cur_last  = c_last;
  assign st.active    = (pts == PTS_ANCHOR) || (pts == PTS_PENDING);
  assign st.pts_one   = (pts == PTS_ANCHOR);
  assign st.no_test   = (p_area != a_area) || ((ac[0] == '0) && (ac[1] == '0) && (ac[2] == '0));
  assign st.removable = acc[AB-1] || (acc == '0);

endmodule

// ===== design/collinear_path_point_pruner_top.sv =====
// Collinear path point pruner.
// Points of a path enter on the in channel (in_valid/in_ready, in_data),
// kept points leave on the out channel (out_valid/out_ready, out_data).
// The distance limit is written on the cfg channel (cfg_valid/cfg_ready,
// cfg_data); cfg_ready is always high, writes are meant for idle periods.
// One point is taken at a time; a small microprogram steps one shared
// multiplier and accumulator through the cross product and length test.
// How long a point takes depends on its place in the path: the first
// point of a path, the second point, a flag mismatch or anchor on the
// new point, and the full distance test (point dropped or kept) each
// take their own route through the microprogram.
// The multiply-accumulate sequence of 23 steps sets the rate while the receiver does not stall.
// A kept point shows on out_valid the cycle after its step; an item can
// produce two kept points, the second waits until the first is taken.
// When the receiver stalls the output register holds its point, and the
// sequencer holds at its emit step, so nothing is lost or repeated.
// Reset clears the path state (next point starts a new path), empties
// the output register and sets the distance limit to 256 coordinate units.
module collinear_path_point_pruner_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  cpp_pkg::point_in_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output cpp_pkg::point_out_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cpp_pkg::DIST_BITS-1:0] cfg_data
);

  cpp_pkg::ctrl_t   cw;
  cpp_pkg::status_t st;

  assign cfg_ready = 1'b1;

  // microprogram sequencer
  cpp_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .st       (st),
    .in_ready (in_ready),
    .cw       (cw)
  );

  // arithmetic and point datapath
  cpp_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cw        (cw),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .st        (st)
  );

endmodule

// ===== design/cpp_chk.sv =====
module cpp_chk (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input cpp_pkg::point_out_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");

  // one point in flight at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while busy");

  // idle block keeps waiting for input
  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready && !in_valid |=> in_ready)
    else $error("ready dropped without a transfer");

  // reset empties the output register
  a_rst_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind collinear_path_point_pruner_top cpp_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASES        = 8;
  localparam int PHASE_POINTS  = 200;

  // predicts kept points and checks them in order
  class kept_point_board;
    cpp_pkg::point_out_t                   kept_q[$];
    logic signed [cpp_pkg::COORD_BITS-1:0] anchor[3];
    logic signed [cpp_pkg::COORD_BITS-1:0] pend[3];
    logic [cpp_pkg::FLAG_BITS-1:0]         anchor_flags;
    logic [cpp_pkg::FLAG_BITS-1:0]         pend_flags;
    int unsigned                           seen;  // 0 new path, 1 anchor only, 2 anchor and pending
    logic [cpp_pkg::DIST_BITS-1:0]         limit;
    int unsigned                           fails;

    function new();
      for (int k = 0; k < 3; k++) begin
        anchor[k] = '0;
        pend[k]   = '0;
      end
      anchor_flags = '0;
      pend_flags   = '0;
      seen         = 0;
      limit        = cpp_pkg::DIST_BITS'(cpp_pkg::DIST_RESET);
      fails        = 0;
    endfunction

    function int waiting();
      return kept_q.size();
    endfunction

    function void push_kept(logic signed [cpp_pkg::COORD_BITS-1:0] x,
                            logic signed [cpp_pkg::COORD_BITS-1:0] y,
                            logic signed [cpp_pkg::COORD_BITS-1:0] z,
                            logic [cpp_pkg::FLAG_BITS-1:0] f,
                            logic last);
      cpp_pkg::point_out_t o;
      o.out_x     = x;
      o.out_y     = y;
      o.out_z     = z;
      o.out_flags = f;
      o.path_end  = last;
      kept_q.push_back(o);
    endfunction

    // exact squared-distance test of the pending point against line anchor -> c
    function bit near_line(cpp_pkg::point_in_t c);
      longint ab[3], ac[3], cr[3];
      logic signed [127:0] w;
      logic [127:0] lhs, len2, rhs;
      ac[0] = longint'(c.pos_x) - longint'(anchor[0]);
      ac[1] = longint'(c.pos_y) - longint'(anchor[1]);
      ac[2] = longint'(c.pos_z) - longint'(anchor[2]);
      for (int k = 0; k < 3; k++)
        ab[k] = longint'(pend[k]) - longint'(anchor[k]);
      // anchor on the new point: no line, keep the midpoint
      if (ac[0] == 0 && ac[1] == 0 && ac[2] == 0)
        return 1'b0;
      cr[0] = ab[1] * ac[2] - ab[2] * ac[1];
      cr[1] = ab[2] * ac[0] - ab[0] * ac[2];
      cr[2] = ab[0] * ac[1] - ab[1] * ac[0];
      lhs  = '0;
      len2 = '0;
      for (int k = 0; k < 3; k++) begin
        w    = cr[k];
        lhs  = lhs + w * w;
        w    = ac[k];
        len2 = len2 + w * w;
      end
      rhs = 128'(limit) * 128'(limit) * len2;
      return lhs <= rhs;
    endfunction

    // note an accepted input point
    function void take_point(cpp_pkg::point_in_t p);
      if (seen == 1 || seen == 2) begin
        if (seen == 2 && !(pend_flags == anchor_flags && near_line(p))) begin
          push_kept(pend[0], pend[1], pend[2], pend_flags, 1'b0);
          anchor       = pend;
          anchor_flags = pend_flags;
        end
        if (p.final_point) begin
          push_kept(p.pos_x, p.pos_y, p.pos_z, p.area_flags, 1'b1);
          seen = 0;
        end else begin
          pend[0]    = p.pos_x;
          pend[1]    = p.pos_y;
          pend[2]    = p.pos_z;
          pend_flags = p.area_flags;
          seen       = 2;
        end
      end else begin
        push_kept(p.pos_x, p.pos_y, p.pos_z, p.area_flags, p.final_point);
        anchor[0]    = p.pos_x;
        anchor[1]    = p.pos_y;
        anchor[2]    = p.pos_z;
        anchor_flags = p.area_flags;
        seen         = p.final_point ? 0 : 1;
      end
    endfunction

    // compare one output transfer with the oldest expected point
    function void check_kept(cpp_pkg::point_out_t got);
      cpp_pkg::point_out_t exp_pt;
      if (kept_q.size() == 0) begin
        if (fails < 10)
          $display("unexpected kept point x=%0d y=%0d z=%0d flags=%h end=%b",
                   got.out_x, got.out_y, got.out_z, got.out_flags, got.path_end);
        fails++;
        return;
      end
      exp_pt = kept_q.pop_front();
      if (got.out_x !== exp_pt.out_x || got.out_y !== exp_pt.out_y ||
          got.out_z !== exp_pt.out_z || got.out_flags !== exp_pt.out_flags ||
          got.path_end !== exp_pt.path_end) begin
        if (fails < 10)
          $display("kept point mismatch: exp %0d %0d %0d %h %b, got %0d %0d %0d %h %b",
                   exp_pt.out_x, exp_pt.out_y, exp_pt.out_z, exp_pt.out_flags,
                   exp_pt.path_end, got.out_x, got.out_y, got.out_z, got.out_flags,
                   got.path_end);
        fails++;
      end
    endfunction
  endclass

  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  cpp_pkg::point_in_t            in_data   = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  cpp_pkg::point_out_t           out_data;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [cpp_pkg::DIST_BITS-1:0] cfg_data  = '0;

  kept_point_board board;
  int unsigned     cycle_count = 0;
  int unsigned     points_sent = 0;
  bit              rx_quiet    = 1'b0;
  bit              tx_quiet    = 1'b0;
  bit              hold_req    = 1'b0;

  collinear_path_point_pruner_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // output transfer check
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.check_kept(out_data);
  end

  // receiver: random gaps after each transfer, one long hold on request
  initial begin : result_sink
    int gap;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  <= 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else if (!rst && out_valid && out_ready) begin
        gap = rx_quiet ? 0 : $urandom_range(0, 18);
        if (gap != 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
          out_ready <= 1'b1;
        end
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic cpp_pkg::point_in_t make_point(int x, int y, int z,
                                                    logic [cpp_pkg::FLAG_BITS-1:0] f,
                                                    logic last);
    cpp_pkg::point_in_t p;
    p.pos_x       = cpp_pkg::COORD_BITS'(x);
    p.pos_y       = cpp_pkg::COORD_BITS'(y);
    p.pos_z       = cpp_pkg::COORD_BITS'(z);
    p.area_flags  = f;
    p.final_point = last;
    return p;
  endfunction

  function automatic int signed_draw(int unsigned a);
    return int'($urandom_range(0, 2 * a)) - int'(a);
  endfunction

  // offer one point and wait for its transfer
  task automatic send_point(cpp_pkg::point_in_t p);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    @(posedge clk iff in_ready);
    board.take_point(p);
    points_sent++;
  endtask

  // stop offering, wait for every expected point, then let the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (board.waiting() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(logic [cpp_pkg::DIST_BITS-1:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk iff cfg_ready);
    cfg_valid <= 1'b0;
    board.limit = v;
  endtask

  // one path: mostly points along a line with noise around the limit
  task automatic random_path();
    int len, kind, amp, sh;
    int cx, cy, cz, dx, dy, dz;
    logic [cpp_pkg::FLAG_BITS-1:0] flags;
    cpp_pkg::point_in_t p;
    len   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
    kind  = $urandom_range(0, 19);
    flags = cpp_pkg::FLAG_BITS'($urandom);
    cx    = int'($urandom_range(0, 1 << 23)) - (1 << 22);
    cy    = int'($urandom_range(0, 1 << 23)) - (1 << 22);
    cz    = int'($urandom_range(0, 1 << 23)) - (1 << 22);
    sh    = $urandom_range(0, 16);
    dx    = signed_draw(1 << sh);
    dy    = signed_draw(1 << sh);
    dz    = signed_draw(1 << sh);
    for (int i = 0; i < len; i++) begin
      if (kind == 0) begin
        // full-range scatter
        p = make_point(int'($urandom), int'($urandom), int'($urandom),
                       cpp_pkg::FLAG_BITS'($urandom), 1'b0);
      end else begin
        if ($urandom_range(0, 9) == 0) begin
          sh = $urandom_range(0, 16);
          dx = signed_draw(1 << sh);
          dy = signed_draw(1 << sh);
          dz = signed_draw(1 << sh);
        end
        case ($urandom_range(0, 4))
          0:       amp = 0;
          1:       amp = board.limit / 2;
          2:       amp = board.limit;
          3:       amp = 2 * board.limit;
          default: amp = $urandom_range(0, 1 << 16);
        endcase
        cx = cx + dx;
        cy = cy + dy;
        cz = cz + dz;
        if ($urandom_range(0, 7) == 0)
          flags = ($urandom_range(0, 1) == 0) ? cpp_pkg::FLAG_BITS'($urandom) : ~flags;
        p = make_point(cx + signed_draw(amp), cy + signed_draw(amp), cz + signed_draw(amp),
                       flags, 1'b0);
        // new point on top of the anchor
        if (i >= 2 && $urandom_range(0, 19) == 0) begin
          p.pos_x = board.anchor[0];
          p.pos_y = board.anchor[1];
          p.pos_z = board.anchor[2];
        end
      end
      p.final_point = (i == len - 1);
      send_point(p);
    end
  endtask

  initial begin
    int unsigned                   phase_start;
    logic [cpp_pkg::DIST_BITS-1:0] lim;
    bit                            paused;
    board = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single point path at the top of the range
    send_point(make_point(8388607, 8388607, 8388607, 16'hFFFF, 1'b1));
    // two point path, second point final
    send_point(make_point(-8388608, -8388608, -8388608, 16'h0000, 1'b0));
    send_point(make_point(0, 0, 0, 16'h0001, 1'b1));
    // drops then a kept corner
    send_point(make_point(0, 0, 0, 16'h00A5, 1'b0));
    send_point(make_point(256, 10, 0, 16'h00A5, 1'b0));
    send_point(make_point(512, 0, 0, 16'h00A5, 1'b0));
    send_point(make_point(1024, 300, 0, 16'h00A5, 1'b0));
    send_point(make_point(1536, 0, 0, 16'h00A5, 1'b1));
    // flag change keeps a collinear point
    send_point(make_point(0, 0, 0, 16'h0001, 1'b0));
    send_point(make_point(100, 0, 0, 16'h0002, 1'b0));
    send_point(make_point(200, 0, 0, 16'h0002, 1'b0));
    send_point(make_point(300, 0, 0, 16'h0002, 1'b1));
    // new point back on the anchor
    send_point(make_point(100, 100, 100, 16'h0007, 1'b0));
    send_point(make_point(200, 150, 100, 16'h0007, 1'b0));
    send_point(make_point(100, 100, 100, 16'h0007, 1'b0));
    send_point(make_point(100, 100, 100, 16'h0007, 1'b1));
    // corner to corner diagonal
    send_point(make_point(-8388608, -8388608, -8388608, 16'h5A5A, 1'b0));
    send_point(make_point(1, 0, -1, 16'h5A5A, 1'b0));
    send_point(make_point(8388607, 8388607, 8388607, 16'h5A5A, 1'b1));
    // far off midpoint
    send_point(make_point(0, 0, 0, 16'h0003, 1'b0));
    send_point(make_point(0, 8388607, 0, 16'h0003, 1'b0));
    send_point(make_point(0, 0, -8388608, 16'h0003, 1'b1));

    // random phases, each under its own distance limit
    paused = 1'b0;
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       lim = '0;
        1:       lim = '1;
        2:       lim = 16'd1;
        3:       lim = 16'd256;
        default: lim = $urandom_range(0, 1) ? cpp_pkg::DIST_BITS'($urandom_range(0, 1023))
                                            : cpp_pkg::DIST_BITS'($urandom);
      endcase
      write_limit(lim);
      rx_quiet <= ($urandom_range(0, 3) == 0);
      tx_quiet <= (phase == 2) || ($urandom_range(0, 3) == 0);
      // long receiver hold while points keep coming
      if (phase == 2)
        hold_req <= 1'b1;
      phase_start = points_sent;
      while (points_sent - phase_start < PHASE_POINTS) begin
        random_path();
        // sender pause until every expected point is out
        if (phase == 5 && !paused && points_sent - phase_start > PHASE_POINTS / 2) begin
          settle();
          paused = 1'b1;
        end
      end
    end

    settle();
    if (board.fails == 0 && board.waiting() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
